/* rtl/core/rau_pkg.sv */
// Package for the rational arithmetic unit: types, widths and shared constants.
`default_nettype none
package rau_pkg;
  localparam int OPERAND_BITS = 16;
  localparam int MAG_BITS     = OPERAND_BITS;
  localparam int PROD_BITS    = 2 * MAG_BITS;
  localparam int WIDE_BITS    = PROD_BITS + 1;
  localparam int NUM_OUT_BITS = 33;
  localparam int DEN_OUT_BITS = 31;
  localparam int CNT_BITS     = $clog2(WIDE_BITS + 1);

  localparam logic [1:0] DIV_GCD = 2'd0;
  localparam logic [1:0] DIV_NUM = 2'd1;
  localparam logic [1:0] DIV_DEN = 2'd2;

  typedef enum logic [1:0] {
    MODE_REDUCE = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_MUL    = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_SUM, ST_CHECK, ST_GCD_START, ST_GCD_RUN,
    ST_GCD_STEP, ST_DIVN_START, ST_DIVN_RUN, ST_DIVD_START, ST_DIVD_RUN, ST_DONE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_start;
    logic div_step;
    logic gcd_step;
    logic [1:0] div_sel;   // gcd remainder, numerator or denominator
    logic store_qn;
    logic store_qd;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic err;
    logic num_zero;
    logic rem_zero;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

/* rtl/core/rational_arith_unit_top.sv */
// Top level of the rational arithmetic unit.
// Channel | Ports                                   | Handshake
// request | mode num_a den_a num_b den_b            | start && !busy
// result  | res_num res_den zero_den_error          | done, one cycle
// One request at a time. Each Euclid remainder step uses the shared 33-bit
// restoring divider (load, 33 shifts, done, swap); after Euclid come two
// quotient divisions. busy stays high through the done cycle; a zero numerator
// or an error skips Euclid and both divisions.
// Synchronous reset returns the controller to idle; the receiver cannot stall.
`default_nettype none
module rational_arith_unit_top
  import rau_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  output logic                                done,
  input  wire logic [1:0]                     mode,
  input  wire logic signed [OPERAND_BITS-1:0] num_a,
  input  wire logic signed [OPERAND_BITS-1:0] den_a,
  input  wire logic signed [OPERAND_BITS-1:0] num_b,
  input  wire logic signed [OPERAND_BITS-1:0] den_b,
  output logic signed [NUM_OUT_BITS-1:0]      res_num,
  output logic [DEN_OUT_BITS-1:0]             res_den,
  output logic                                zero_den_error
);
  ctrl_t ctrl;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .ctrl(ctrl), .busy(busy), .done(done)
  );

  rau_datapath u_dp (
    .clk(clk), .ctrl(ctrl), .stat(stat), .mode(mode), .num_a(num_a), .den_a(den_a),
    .num_b(num_b), .den_b(den_b), .res_num(res_num), .res_den(res_den),
    .zero_den_error(zero_den_error)
  );
endmodule
`default_nettype wire

/* rtl/core/rau_datapath.sv */
// Datapath: operand products, sum, shared restoring divider for Euclid and final quotients.
`default_nettype none
module rau_datapath
  import rau_pkg::*;
(
  input  wire logic                          clk,
  input  wire ctrl_t                         ctrl,
  output stat_t                              stat,
  input  wire logic [1:0]                    mode,
  input  wire logic signed [OPERAND_BITS-1:0] num_a,
  input  wire logic signed [OPERAND_BITS-1:0] den_a,
  input  wire logic signed [OPERAND_BITS-1:0] num_b,
  input  wire logic signed [OPERAND_BITS-1:0] den_b,
  output logic signed [NUM_OUT_BITS-1:0]     res_num,
  output logic [DEN_OUT_BITS-1:0]            res_den,
  output logic                               zero_den_error
);
  logic [1:0]           op;
  logic                 sna, sda, snb, sdb;
  logic [MAG_BITS-1:0]  mna, mda, mnb, mdb;
  logic [PROD_BITS-1:0] p1, p2, dprod;
  logic                 p1n, p2n;
  logic [WIDE_BITS-1:0] nmag, dmag, gx, gy, qn, qd;
  logic                 nneg, err;
  logic [WIDE_BITS-1:0] dvd, dvs, quo, rem;
  logic [CNT_BITS-1:0]  cnt;
  logic [WIDE_BITS:0]   trial;
  logic [PROD_BITS-1:0] ma_b, mb_a;

  function automatic logic [MAG_BITS-1:0] magof(input logic [OPERAND_BITS-1:0] v);
    return v[OPERAND_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
  endfunction

  assign ma_b  = PROD_BITS'(op == MODE_MUL ? mna : mna) * PROD_BITS'(op == MODE_MUL ? mnb : mdb);
  assign mb_a  = PROD_BITS'(op == MODE_MUL ? mda : mnb) * PROD_BITS'(op == MODE_MUL ? mdb : mda);
  assign trial = {rem, dvd[WIDE_BITS-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op  <= mode;
      sna <= num_a[OPERAND_BITS-1]; mna <= magof(num_a);
      sda <= den_a[OPERAND_BITS-1]; mda <= magof(den_a);
      snb <= num_b[OPERAND_BITS-1]; mnb <= magof(num_b);
      sdb <= den_b[OPERAND_BITS-1]; mdb <= magof(den_b);
    end
    if (ctrl.mul1) begin
      p1  <= ma_b;
      p1n <= (op == MODE_MUL) ? (sna ^ snb) : (sna ^ sdb);
      p2  <= mb_a;
      p2n <= (op == MODE_MUL) ? (sda ^ sdb) : (snb ^ sda);
    end
    if (ctrl.mul2) begin
      dprod <= PROD_BITS'(mda) * PROD_BITS'(mdb);
    end
    if (ctrl.sum) begin
      unique case (op)
        MODE_ADD: begin
          err  <= (mda == '0) || (mdb == '0);
          dmag <= WIDE_BITS'(dprod);
          if (p1n == p2n) begin
            nmag <= WIDE_BITS'(p1) + WIDE_BITS'(p2); nneg <= p1n ^ sda ^ sdb;
          end else if (p1 >= p2) begin
            nmag <= WIDE_BITS'(p1 - p2); nneg <= p1n ^ sda ^ sdb;
          end else begin
            nmag <= WIDE_BITS'(p2 - p1); nneg <= p2n ^ sda ^ sdb;
          end
        end
        MODE_MUL: begin
          err  <= (mda == '0) || (mdb == '0);
          nmag <= WIDE_BITS'(p1); dmag <= WIDE_BITS'(p2);
          nneg <= p1n ^ p2n;
        end
        default: begin
          err  <= (mda == '0);
          nmag <= WIDE_BITS'(mna); dmag <= WIDE_BITS'(mda);
          nneg <= sna ^ sda;
        end
      endcase
    end
    if (ctrl.load) begin
      gx <= '0; gy <= '0;
    end else if (ctrl.sum) begin
      gx <= '0; gy <= '0;
    end else if (ctrl.div_start && ctrl.div_sel == DIV_GCD && gy == '0 && gx == '0) begin
      gx <= nmag; gy <= dmag;
    end
    if (ctrl.gcd_step) begin
      gx <= gy; gy <= rem;
    end
    if (ctrl.div_start) begin
      unique case (ctrl.div_sel)
        DIV_NUM: begin dvd <= nmag; dvs <= gx; end
        DIV_DEN: begin dvd <= dmag; dvs <= gx; end
        default: begin
          if (gy == '0 && gx == '0) begin dvd <= nmag; dvs <= dmag; end
          else begin dvd <= gx; dvs <= gy; end
        end
      endcase
      rem <= '0; quo <= '0; cnt <= '0;
    end else if (ctrl.div_step) begin
      if (!trial[WIDE_BITS]) begin
        rem <= trial[WIDE_BITS-1:0]; quo <= {quo[WIDE_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[WIDE_BITS-2:0], dvd[WIDE_BITS-1]}; quo <= {quo[WIDE_BITS-2:0], 1'b0};
      end
      dvd <= {dvd[WIDE_BITS-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
    if (ctrl.store_qn) qn <= quo;
    if (ctrl.store_qd) qd <= quo;
    if (ctrl.finish) begin
      zero_den_error <= err;
      if (err) begin
        res_num <= '0; res_den <= '0;
      end else if (nmag == '0) begin
        res_num <= '0; res_den <= DEN_OUT_BITS'(1);
      end else begin
        res_num <= nneg ? NUM_OUT_BITS'(-qn) : NUM_OUT_BITS'(qn);
        res_den <= qd[DEN_OUT_BITS-1:0];
      end
    end
  end

  assign stat.err      = err;
  assign stat.num_zero = (nmag == '0);
  assign stat.rem_zero = (rem == '0);
  assign stat.div_done = (cnt == CNT_BITS'(WIDE_BITS));
endmodule
`default_nettype wire

/* rtl/core/rau_ctrl.sv */
// Controller: sequences products, Euclid's loop and the two final divisions.
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output ctrl_t      ctrl,
  output logic       busy,
  output logic       done
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (start) state_next = ST_MUL1;
      ST_MUL1:       state_next = ST_MUL2;
      ST_MUL2:       state_next = ST_SUM;
      ST_SUM:        state_next = ST_CHECK;
      ST_CHECK:      state_next = (stat.err || stat.num_zero) ? ST_DONE : ST_GCD_START;
      ST_GCD_START:  state_next = ST_GCD_RUN;
      ST_GCD_RUN:    if (stat.div_done) state_next = ST_GCD_STEP;
      ST_GCD_STEP:   state_next = stat.rem_zero ? ST_DIVN_START : ST_GCD_START;
      ST_DIVN_START: state_next = ST_DIVN_RUN;
      ST_DIVN_RUN:   if (stat.div_done) state_next = ST_DIVD_START;
      ST_DIVD_START: state_next = ST_DIVD_RUN;
      ST_DIVD_RUN:   if (stat.div_done) state_next = ST_DONE;
      ST_DONE:       state_next = ST_RESULT;
      ST_RESULT:     state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    busy      = (state != ST_IDLE);
    done      = (state == ST_RESULT);
    ctrl.load = (state == ST_IDLE) && start;
    ctrl.mul1 = (state == ST_MUL1);
    ctrl.mul2 = (state == ST_MUL2);
    ctrl.sum  = (state == ST_SUM);
    ctrl.finish = (state == ST_DONE);
    unique case (state)
      ST_GCD_START:  begin ctrl.div_start = 1'b1; ctrl.div_sel = DIV_GCD; end
      ST_DIVN_START: begin ctrl.div_start = 1'b1; ctrl.div_sel = DIV_NUM; end
      ST_DIVD_START: begin ctrl.div_start = 1'b1; ctrl.div_sel = DIV_DEN; end
      ST_GCD_RUN:    ctrl.div_step = !stat.div_done;
      ST_DIVN_RUN:   begin ctrl.div_step = !stat.div_done; ctrl.store_qn = stat.div_done; end
      ST_DIVD_RUN:   begin ctrl.div_step = !stat.div_done; ctrl.store_qd = stat.div_done; end
      ST_GCD_STEP:   ctrl.gcd_step = 1'b1;
      default:       ;
    endcase
  end
endmodule
`default_nettype wire
